>>> design/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Shared types, constants and the alphabet lookup for the encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CHAR_W      = 7;
	localparam int unsigned GROUP_W     = 6;
	localparam int unsigned SLOTS       = 4;
	localparam int unsigned SLOT_IDX_W  = 2;
	localparam int unsigned FIFO_DEPTH  = 2;
	localparam int unsigned FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'h3D;
	localparam logic [CHAR_W-1:0] UPPER_BASE = 7'h41;
	localparam logic [CHAR_W-1:0] LOWER_BASE = 7'h61;
	localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'h30;
	localparam logic [CHAR_W-1:0] PLUS_CHAR  = 7'h2B;
	localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'h2F;

	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		char_t [SLOTS-1:0]      chars;
		logic [SLOT_IDX_W-1:0]  num;
		logic                   fin;
	} entry_t;

	function automatic char_t b64_char(input logic [GROUP_W-1:0] v);
		char_t c;
		c = SLASH_CHAR;
		case (v) inside
			[6'd0:6'd25]:  c = UPPER_BASE + char_t'(v);
			[6'd26:6'd51]: c = LOWER_BASE + char_t'(v - 6'd26);
			[6'd52:6'd61]: c = DIGIT_BASE + char_t'(v - 6'd52);
			6'd62:         c = PLUS_CHAR;
			default:       c = SLASH_CHAR;
		endcase
		return c;
	endfunction

endpackage

>>> design/base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Streams raw bytes into standard base64 characters with '=' padding.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while full is low; the front end turns it
// into all of its characters (one or two, up to four on a last byte) in the
// cycle it is taken and writes them as one entry into a two-entry queue. The
// entry is registered in the queue, and the back end presents the head entry's
// characters combinationally. Characters leave one per cycle while pop is high
// through the single result port, and that port sets the sustained rate; full
// rises when both queue entries are waiting.
module base64_stream_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [b64e_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          last_byte,
	input  logic                          push,
	output logic                          full,
	output logic [b64e_pkg::CHAR_W-1:0]   code_char,
	output logic                          last_char,
	output logic                          empty,
	input  logic                          pop
);
	import b64e_pkg::*;

	entry_t wr_entry;
	entry_t head;
	logic   wr_en;
	logic   head_valid;
	logic   head_pop;

	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push),
		.q_full    (full),
		.q_push    (wr_en),
		.q_entry   (wr_entry)
	);

	b64e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.full     (full),
		.rd_en    (head_pop),
		.rd_entry (head),
		.rd_valid (head_valid)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.code_char  (code_char),
		.last_char  (last_char),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

>>> design/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, merges them with the leftover bits and builds one queue
// entry holding every character that the byte produces.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [b64e_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          last_byte,
	input  logic                          push,
	input  logic                          q_full,
	output logic                          q_push,
	output b64e_pkg::entry_t              q_entry
);
	import b64e_pkg::*;

	logic [3:0]  leftover_bits_q;
	logic [2:0]  leftover_count_q;
	logic [3:0]  n;
	logic [11:0] acc;
	logic        two;
	logic [3:0]  sh0;
	logic [3:0]  sh1;
	logic [5:0]  grp0;
	logic [5:0]  grp1;
	logic [2:0]  rem_n;
	logic [4:0]  rem_bits;
	logic [5:0]  tail;
	logic [2:0]  idx;
	logic        take;

	assign take   = push && !q_full;
	assign q_push = take;

	always_comb begin
		n        = {1'b0, leftover_count_q} + 4'd8;
		acc      = {leftover_bits_q, data_byte};
		two      = (n >= 4'd12);
		sh0      = n - 4'd6;
		sh1      = n - 4'd12;
		grp0     = 6'(acc >> sh0);
		grp1     = 6'(acc >> sh1);
		rem_n    = two ? 3'(sh1) : 3'(sh0);
		rem_bits = 5'(acc & ((12'd1 << rem_n) - 12'd1));
		tail     = 6'({6'd0, rem_bits} << (3'd6 - rem_n));

		q_entry.chars = {SLOTS{PAD_CHAR}};
		q_entry.chars[0] = b64_char(grp0);
		idx = 3'd1;
		if (two) begin
			q_entry.chars[1] = b64_char(grp1);
			idx = 3'd2;
		end
		if (last_byte && (rem_n != 3'd0)) begin
			q_entry.chars[idx[SLOT_IDX_W-1:0]] = b64_char(tail);
			idx = idx + 3'd1;
			if (rem_n == 3'd2) begin
				idx = idx + 3'd2;
			end else if (rem_n == 3'd4) begin
				idx = idx + 3'd1;
			end
		end
		q_entry.num = SLOT_IDX_W'(idx - 3'd1);
		q_entry.fin = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_bits_q  <= '0;
			leftover_count_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				leftover_bits_q  <= '0;
				leftover_count_q <= '0;
			end else begin
				leftover_bits_q  <= rem_bits[3:0];
				leftover_count_q <= rem_n;
			end
		end
	end

endmodule

>>> design/b64e_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder entry queue
// Short queue of character entries between the front end and the back end.
// ----------------------------------------------------------------------------
module b64e_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  b64e_pkg::entry_t  wr_entry,
	output logic              full,
	input  logic              rd_en,
	output b64e_pkg::entry_t  rd_entry,
	output logic              rd_valid
);
	import b64e_pkg::*;

	entry_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic                    do_wr;
	logic                    do_rd;

	assign full     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

>>> design/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Walks the characters of the head entry, one per pop, and retires the entry
// after its final character.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  b64e_pkg::entry_t               head,
	input  logic                           head_valid,
	output logic                           head_pop,
	output logic [b64e_pkg::CHAR_W-1:0]    code_char,
	output logic                           last_char,
	output logic                           empty,
	input  logic                           pop
);
	import b64e_pkg::*;

	logic [SLOT_IDX_W-1:0] slot_q;
	logic                  at_end;
	logic                  take;

	assign empty     = !head_valid;
	assign take      = pop && head_valid;
	assign at_end    = (slot_q == head.num);
	assign code_char = head.chars[slot_q];
	assign last_char = head.fin && at_end;
	assign head_pop  = take && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (take) begin
			// advance within the entry, rewind once it retires
			slot_q <= at_end ? '0 : slot_q + SLOT_IDX_W'(1);
		end
	end

endmodule

>>> design/b64e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 encoder port checker
// Watches the top-level ports for ordering and character-set slips.
// ----------------------------------------------------------------------------
module b64e_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [b64e_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          last_byte,
	input  logic                          push,
	input  logic                          full,
	input  logic [b64e_pkg::CHAR_W-1:0]   code_char,
	input  logic                          last_char,
	input  logic                          empty,
	input  logic                          pop
);
	import b64e_pkg::*;

	logic unused_in;
	assign unused_in = ^{data_byte, last_byte};

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((code_char >= 7'h41 && code_char <= 7'h5A) ||
			(code_char >= 7'h61 && code_char <= 7'h7A) ||
			(code_char >= 7'h30 && code_char <= 7'h39) ||
			code_char == PLUS_CHAR || code_char == SLASH_CHAR ||
			code_char == PAD_CHAR))
		else $error("b64e: character outside the alphabet");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(code_char) && $stable(last_char)))
		else $error("b64e: stalled item changed");

	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && code_char == PAD_CHAR && !last_char) |=>
			(!empty && code_char == PAD_CHAR))
		else $error("b64e: pad run broken");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && empty) |=> !empty)
		else $error("b64e: accepted item produced no result");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);
